### hdl/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

   typedef logic [31:0] word_type;
   // eight 32-bit words, index 0 is word a / most significant digest word
   typedef logic [7:0][31:0] hash_type;

   localparam int BlockWords = 16;
   localparam int Rounds     = 64;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   // Control from the sequencer to the schedule and round units
   typedef struct packed {
      logic load;   // take a message word / load working variables
      logic step;   // advance by one round
   } ctl_type;

   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_s0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_s1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_s0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_s1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

### hdl/sha_sched.sv
`timescale 1ns / 1ps
`default_nettype none

// Message schedule: a 16-word shift line holding w[t] .. w[t+15].
module sha_sched (
   input  wire              clock,
   input  sha_pkg::ctl_type ctl,
   input  sha_pkg::word_type msg_word,
   output sha_pkg::word_type sched_word
);
   import sha_pkg::*;

   word_type win_ff [BlockWords];
   word_type win_in [BlockWords];
   word_type expand;

   // w[t+16] from the window taps
   assign expand = small_s1(win_ff[14]) + win_ff[9] + small_s0(win_ff[1]) + win_ff[0];
   assign sched_word = win_ff[0];

   // shift towards slot 0; new word enters at the top
   always_comb begin
      for (int i = 0; i < BlockWords - 1; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      win_in[BlockWords - 1] = ctl.load ? msg_word : expand;
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      if (ctl.load || ctl.step) begin
         win_ff <= win_in;
      end
   end

endmodule

`default_nettype wire

### hdl/sha_round.sv
`timescale 1ns / 1ps
`default_nettype none

// Compression round unit: one round of a..h per step.
module sha_round (
   input  wire               clock,
   input  sha_pkg::ctl_type  ctl,
   input  sha_pkg::hash_type chain,
   input  sha_pkg::word_type sched_word,
   input  wire [5:0]         round_idx,
   output sha_pkg::hash_type work
);
   import sha_pkg::*;

   hash_type work_ff;
   hash_type work_in;
   word_type t1;
   word_type t2;
   word_type ch;
   word_type maj;

   assign work = work_ff;

   // round function
   always_comb begin
      ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
          ^ (work_ff[1] & work_ff[2]);
      t1  = work_ff[7] + big_s1(work_ff[4]) + ch + ROUND_K[round_idx] + sched_word;
      t2  = big_s0(work_ff[0]) + maj;
      if (ctl.load) begin
         work_in = chain;
      end else begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load || ctl.step) begin
         work_ff <= work_in;
      end
   end

endmodule

`default_nettype wire

### hdl/sha256_block_compressor_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                                   Beat
// req       in         req_message_word, req_start_message    one message word
// rsp       out        rsp_digest_word, rsp_word_position,    one digest word
//                      rsp_last_word
//
// A block is loaded as 16 words (one word a cycle while req_valid is
// high), then runs 64 rounds through the single round unit, is added
// into the chaining value and emits its eight digest words.
// Reset loads the standard initial hash values and clears the counters.
// req_stall is high unless loading; rsp_stall holds the current digest
// word, and the next block is not taken until all eight have gone.
module sha256_block_compressor_top (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [31:0] req_message_word,
   input  wire        req_start_message,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0] rsp_word_position,
   output logic       rsp_last_word
);
   import sha_pkg::*;

   state_type state_ff, state_in;
   hash_type  chain_ff, chain_in;
   logic [3:0] word_count_ff, word_count_in;
   logic [5:0] round_count_ff, round_count_in;
   logic [2:0] out_idx_ff, out_idx_in;
   ctl_type   ctl;
   word_type  sched_word;
   hash_type  work;
   logic      req_take;

   sha_sched u_sched (
      .clock      (clock),
      .ctl        (ctl),
      .msg_word   (req_message_word),
      .sched_word (sched_word)
   );

   sha_round u_round (
      .clock      (clock),
      .ctl        (ctl),
      .chain      (chain_ff),
      .sched_word (sched_word),
      .round_idx  (round_count_ff),
      .work       (work)
   );

   assign req_stall = (state_ff != ST_LOAD);
   assign req_take  = req_valid && !req_stall;

   // digest output straight from the chaining value
   assign rsp_valid         = (state_ff == ST_OUT);
   assign rsp_digest_word   = chain_ff[out_idx_ff];
   assign rsp_word_position = out_idx_ff;
   assign rsp_last_word     = (out_idx_ff == 3'd7);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      chain_in       = chain_ff;
      word_count_in  = word_count_ff;
      round_count_in = round_count_ff;
      out_idx_in     = out_idx_ff;
      ctl            = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               ctl.load      = 1'b1;
               word_count_in = word_count_ff + 4'd1;
               if (word_count_ff == 4'd0 && req_start_message) begin
                  chain_in = INIT_HASH;
               end
               if (word_count_ff == 4'd15) begin
                  round_count_in = '0;
                  state_in       = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            ctl.step       = 1'b1;
            round_count_in = round_count_ff + 6'd1;
            if (round_count_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int j = 0; j < 8; j++) begin
               chain_in[j] = chain_ff[j] + work[j];
            end
            out_idx_in = '0;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         chain_ff       <= INIT_HASH;
         word_count_ff  <= '0;
         round_count_ff <= '0;
         out_idx_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         chain_ff       <= chain_in;
         word_count_ff  <= word_count_in;
         round_count_ff <= round_count_in;
         out_idx_ff     <= out_idx_in;
      end
   end

endmodule

`default_nettype wire

### tb/tb_sha256_block_compressor_top.sv
`timescale 1ns / 1ps

module tb_sha256_block_compressor_top;

   // SHA-256 round constants and initial hash value, index 0 = word a
   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam int RandomWords = 356;
   localparam int QuietFirst  = 150;   // no idling on either side in this stretch
   localparam int QuietLast   = 250;
   localparam int DrainCycles = 200;

   typedef struct {
      logic [31:0] digest;
      logic [2:0]  position;
      logic        last;
   } digest_beat_t;

   // Tracks the chaining value and the block being loaded; holds the digest
   // beats still owed by the block.
   class sha256_scoreboard;
      logic [31:0]  chain [8];
      logic [31:0]  block_words [16];
      int unsigned  fill;
      digest_beat_t owed [$];
      int unsigned  errors, words_taken, blocks_done, beats_checked, restarts;

      function new();
         chain = SHA_H0;
         fill = 0;
         errors = 0;
         words_taken = 0;
         blocks_done = 0;
         beats_checked = 0;
         restarts = 0;
      endfunction

      static function logic [31:0] rotr(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // 64 rounds over the loaded block, then fold into the chaining value
      function void compress();
         logic [31:0] sched [64];
         logic [31:0] v [8];
         logic [31:0] t1, t2, s0, s1;
         for (int i = 0; i < 64; i++) begin
            if (i < 16)
               sched[i] = block_words[i];
            else begin
               s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
               s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
               sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
            end
         end
         v = chain;
         for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + sched[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         for (int j = 0; j < 8; j++) begin
            chain[j] = chain[j] + v[j];
            owed.push_back('{digest: chain[j], position: 3'(j), last: (j == 7)});
         end
         blocks_done++;
      endfunction

      // One accepted message word; the start flag only counts on a block's first word
      function void note_word(logic [31:0] w, logic start);
         if (fill == 0 && start) begin
            chain = SHA_H0;
            restarts++;
         end
         block_words[fill] = w;
         words_taken++;
         if (fill == 15) begin
            compress();
            fill = 0;
         end else
            fill++;
      endfunction

      function void check_digest(logic [31:0] digest, logic [2:0] position, logic last);
         digest_beat_t exp_beat;
         if (owed.size() == 0) begin
            $error("digest beat with none owed: digest_word %h position %0d", digest, position);
            errors++;
            return;
         end
         exp_beat = owed.pop_front();
         beats_checked++;
         if (digest !== exp_beat.digest) begin
            $error("digest_word: expected %h, actual %h", exp_beat.digest, digest);
            errors++;
         end
         if (position !== exp_beat.position) begin
            $error("word_position: expected %0d, actual %0d", exp_beat.position, position);
            errors++;
         end
         if (last !== exp_beat.last) begin
            $error("last_word: expected %0b, actual %0b", exp_beat.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_message_word = '0;
   logic        req_start_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_position;
   logic        rsp_last_word;

   sha256_scoreboard sb = new();
   int unsigned      words_sent = 0;
   logic             quiet = 1'b0;

   sha256_block_compressor_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_message_word  (req_message_word),
      .req_start_message (req_start_message),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_digest_word   (rsp_digest_word),
      .rsp_word_position (rsp_word_position),
      .rsp_last_word     (rsp_last_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !reset && !quiet && ($urandom_range(0, 99) < 32);
   end

   // Digest beat monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_digest(rsp_digest_word, rsp_word_position, rsp_last_word);
   end

   // Drive one message word beat and hold it until taken
   task automatic send_word(input logic [31:0] w, input logic start);
      if (!quiet && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_message_word  <= w;
      req_start_message <= start;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_word(w, start);
      words_sent++;
      quiet = (words_sent >= QuietFirst && words_sent < QuietLast);
   endtask

   // Word values biased towards the extremes and single set or cleared bits
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h1 << $urandom_range(0, 31);
         3:       return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // "abc" block with no start flag after reset; flags on later words are ignored
      send_word(32'h61626380, 1'b0);
      for (int i = 1; i < 15; i++) send_word(32'h0, (i == 3 || i == 9));
      send_word(32'h00000018, 1'b1);
      // new message of all-ones words, restarted by the flag
      for (int i = 0; i < 8; i++) send_word(32'hffff_ffff, (i == 0));

      // random messages: mostly fresh starts on block boundaries, some continued
      for (int n = 0; n < RandomWords; n++) begin
         if (sb.fill == 0)
            start = ($urandom_range(0, 3) != 0);
         else
            start = ($urandom_range(0, 7) == 0);
         send_word(pick_word(), start);
      end
      req_valid <= 1'b0;

      // drain outstanding digests, then watch for strays
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Run covered %0d message words, %0d blocks and %0d message restarts;",
               sb.words_taken, sb.blocks_done, sb.restarts);
      $display("%0d digest beats checked, %0d mismatches.", sb.beats_checked, sb.errors);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Timed out with %0d digest beats outstanding.", sb.owed.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### files.f
hdl/sha_pkg.sv
hdl/sha_sched.sv
hdl/sha_round.sv
hdl/sha256_block_compressor_top.sv
tb/tb_sha256_block_compressor_top.sv
